// ===== rtl/tfnm_pkg.sv =====
// Shared types and constants for the trie field name matcher.
// Holds the request and result beat types, operation and status codes,
// and the command and status groups between the controller and the datapath.
package tfnm_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CLOSE  = 2'd1;
  localparam logic [1:0] OP_MATCH  = 2'd2;
  localparam logic [1:0] OP_END    = 2'd3;

  localparam logic [2:0] ST_MATCHED      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN      = 3'd1;
  localparam logic [2:0] ST_UNTERMINATED = 3'd2;
  localparam logic [2:0] ST_STORED       = 3'd3;
  localparam logic [2:0] ST_REJECTED     = 3'd4;

  localparam logic [7:0] QUOTE_BYTE = 8'h22;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] character;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] field_num;
  } result_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

// ===== rtl/tfnm_controller.sv =====
// Controller state machine for the trie field name matcher.
// Sequences the memory clearing sweep and the handling of each beat: a load, then an exec step.
// Depends on tfnm_pkg.
module tfnm_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tfnm_pkg::dp_status_t stat,
  output tfnm_pkg::dp_cmd_t   cmd,
  output logic                busy
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  assign busy      = (state != S_IDLE);
  assign cmd.clear = (state == S_CLEAR);
  assign cmd.load  = (state == S_IDLE) && start;
  assign cmd.exec  = (state == S_EXEC);

endmodule

// ===== rtl/tfnm_datapath.sv =====
// Datapath for the trie field name matcher: edge memory, node field memory,
// build and match registers, and the result register.
// Depends on tfnm_pkg; driven by tfnm_controller commands.
module tfnm_datapath #(
  parameter int TRIE_NODES   = 64,
  parameter int MAX_KEYWORDS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tfnm_pkg::dp_cmd_t    cmd,
  input  tfnm_pkg::request_t   request,
  output tfnm_pkg::dp_status_t stat,
  output logic                 done,
  output tfnm_pkg::result_t    result
);

  localparam int NW         = (TRIE_NODES > 1) ? $clog2(TRIE_NODES) : 1;
  localparam int AW         = NW + 8;
  localparam int UW         = $clog2(TRIE_NODES + 1);
  localparam int FW         = $clog2(MAX_KEYWORDS + 1);
  localparam int EDGE_DEPTH = TRIE_NODES * 256;

  logic [NW-1:0] edge_mem [EDGE_DEPTH];
  logic [FW-1:0] field_mem [TRIE_NODES];

  logic [AW-1:0] clear_cnt;
  logic [NW-1:0] edge_rd;
  logic [FW-1:0] field_rd;
  logic [1:0]    op;
  logic [7:0]    chr;

  logic [NW-1:0] build_node, build_node_next;
  logic [UW-1:0] nodes_used, nodes_used_next;
  logic [FW-1:0] kw_stored, kw_stored_next;
  logic          build_failed, build_failed_next;
  logic [NW-1:0] match_node, match_node_next;
  logic          in_unknown, in_unknown_next;
  logic          match_active, match_active_next;

  logic          edge_we;
  logic [AW-1:0] edge_wa;
  logic [NW-1:0] edge_wd;
  logic          field_we;
  logic [NW-1:0] field_wa;
  logic [FW-1:0] field_wd;
  logic          res_valid;
  tfnm_pkg::result_t res;
  logic [FW-1:0] field_m1;

  assign stat.clear_last = (clear_cnt == AW'(EDGE_DEPTH - 1));
  assign field_m1        = field_rd - FW'(1);

  always_comb begin
    build_node_next   = build_node;
    nodes_used_next   = nodes_used;
    kw_stored_next    = kw_stored;
    build_failed_next = build_failed;
    match_node_next   = match_node;
    in_unknown_next   = in_unknown;
    match_active_next = match_active;
    edge_we           = 1'b0;
    edge_wa           = {build_node, chr};
    edge_wd           = nodes_used[NW-1:0];
    field_we          = 1'b0;
    field_wa          = build_node;
    field_wd          = kw_stored + FW'(1);
    res_valid         = 1'b0;
    res               = '0;
    if (cmd.clear) begin
      edge_we  = 1'b1;
      edge_wa  = clear_cnt;
      edge_wd  = '0;
      field_we = (clear_cnt[7:0] == 8'd0);
      field_wa = clear_cnt[AW-1:8];
      field_wd = '0;
    end else if (cmd.exec) begin
      unique case (op)
        tfnm_pkg::OP_INSERT: begin
          if (!build_failed) begin
            if (chr == tfnm_pkg::QUOTE_BYTE) begin
              build_failed_next = 1'b1;
            end else if (edge_rd == '0) begin
              if (nodes_used == UW'(TRIE_NODES)) begin
                build_failed_next = 1'b1;
              end else begin
                edge_we         = 1'b1;
                build_node_next = nodes_used[NW-1:0];
                nodes_used_next = nodes_used + UW'(1);
              end
            end else begin
              build_node_next = edge_rd;
            end
          end
        end
        tfnm_pkg::OP_CLOSE: begin
          res_valid = 1'b1;
          if (build_failed || (kw_stored == FW'(MAX_KEYWORDS))) begin
            res.status = tfnm_pkg::ST_REJECTED;
          end else begin
            field_we       = 1'b1;
            res.status     = tfnm_pkg::ST_STORED;
            res.field_num  = 5'(kw_stored);
            kw_stored_next = kw_stored + FW'(1);
          end
          build_node_next   = '0;
          build_failed_next = 1'b0;
        end
        tfnm_pkg::OP_MATCH: begin
          if (chr == tfnm_pkg::QUOTE_BYTE) begin
            res_valid = 1'b1;
            if (in_unknown || (field_rd == '0)) begin
              res.status = tfnm_pkg::ST_UNKNOWN;
            end else begin
              res.status    = tfnm_pkg::ST_MATCHED;
              res.field_num = 5'(field_m1);
            end
            match_active_next = 1'b0;
            match_node_next   = '0;
            in_unknown_next   = 1'b0;
          end else begin
            match_active_next = 1'b1;
            if (!in_unknown) begin
              if (edge_rd == '0) in_unknown_next = 1'b1;
              else               match_node_next = edge_rd;
            end
          end
        end
        tfnm_pkg::OP_END: begin
          if (match_active) begin
            res_valid         = 1'b1;
            res.status        = tfnm_pkg::ST_UNTERMINATED;
            match_active_next = 1'b0;
            match_node_next   = '0;
            in_unknown_next   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    if (cmd.load) begin
      edge_rd <= edge_mem[{(request.operation == tfnm_pkg::OP_INSERT) ? build_node
                                                                       : match_node,
                           request.character}];
    end
  end

  always_ff @(posedge clk) begin
    if (field_we) field_mem[field_wa] <= field_wd;
    if (cmd.load) field_rd <= field_mem[match_node];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= request.operation;
      chr <= request.character;
    end
    result <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt    <= '0;
      build_node   <= '0;
      nodes_used   <= UW'(1);
      kw_stored    <= '0;
      build_failed <= 1'b0;
      match_node   <= '0;
      in_unknown   <= 1'b0;
      match_active <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cmd.clear) clear_cnt <= clear_cnt + AW'(1);
      build_node   <= build_node_next;
      nodes_used   <= nodes_used_next;
      kw_stored    <= kw_stored_next;
      build_failed <= build_failed_next;
      match_node   <= match_node_next;
      in_unknown   <= in_unknown_next;
      match_active <= match_active_next;
      done         <= res_valid;
    end
  end

endmodule

// ===== rtl/trie_field_name_matcher.sv =====
// Top level of the trie field name matcher.
// Joins tfnm_controller and tfnm_datapath; depends on tfnm_pkg.
//
// Usage: a request beat (operation, character) is taken on a rising edge
// where start is high and busy is low. Insert and close beats build a byte
// trie of keywords; match beats carry the bytes of a quoted identifier after
// its opening quote, and the closing quote reports the field id or unknown.
// End of text during a match reports unterminated.
// Each beat reads the edge and node field memories, then updates the trie
// and match state. The result beat, when there is one, is shown on result
// with done high, in the cycle after that update, while the next request
// can already be taken. A new beat is accepted only after the previous
// beat's update, since the edge memory read must be followed by it.
// The receiver cannot stall: each result is valid for that one cycle only.
// After reset, busy stays high while the edge memory is swept clear, one
// entry per cycle, each node field memory entry with its node's first edge.
module trie_field_name_matcher #(
  parameter int TRIE_NODES   = 64,
  parameter int MAX_KEYWORDS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tfnm_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output tfnm_pkg::result_t  result
);

  tfnm_pkg::dp_cmd_t    cmd;
  tfnm_pkg::dp_status_t stat;

  tfnm_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tfnm_datapath #(
    .TRIE_NODES   (TRIE_NODES),
    .MAX_KEYWORDS (MAX_KEYWORDS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

// ===== rtl/tfnm_checker.sv =====
// Port-level checks for the trie field name matcher, and the bind that
// attaches them to trie_field_name_matcher. Depends on tfnm_pkg.
module tfnm_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input tfnm_pkg::result_t  result
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted beat");

  a_two_cycle_beat: assert property (@(posedge clk) disable iff (rst)
    busy && $past(start && !busy) |=> !busy)
    else $error("beat took more than two cycles");

  a_done_follows_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a beat in progress");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == tfnm_pkg::ST_MATCHED || result.status == tfnm_pkg::ST_UNKNOWN
              || result.status == tfnm_pkg::ST_UNTERMINATED
              || result.status == tfnm_pkg::ST_STORED
              || result.status == tfnm_pkg::ST_REJECTED))
    else $error("status code out of range");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == tfnm_pkg::ST_UNKNOWN
             || result.status == tfnm_pkg::ST_UNTERMINATED
             || result.status == tfnm_pkg::ST_REJECTED) |-> result.field_num == 5'd0)
    else $error("field id not zero for a status without an id");

endmodule

bind trie_field_name_matcher tfnm_checker u_tfnm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== sim/trie_field_name_matcher_test.sv =====
// Self-checking testbench for trie_field_name_matcher: builds a keyword trie and matches
// directed and random identifiers against it, predicting every result beat.
// Depends on tfnm_pkg and the RTL of trie_field_name_matcher only.
module trie_field_name_matcher_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_COUNT    = 64;
  localparam int KEYWORD_LIMIT = 32;
  localparam int VOCAB_MAX     = 96;

  logic               clk;
  logic               rst;
  logic               start;
  tfnm_pkg::request_t request;
  logic               busy;
  logic               done;
  tfnm_pkg::result_t  result;

  bit [6:0] trie_edge [NODE_COUNT*256];
  bit [5:0] node_tag [NODE_COUNT];
  int       kw_node;
  int       nodes_taken;
  int       kw_count;
  bit       kw_failed;
  int       id_node;
  bit       id_lost;
  bit       id_active;

  tfnm_pkg::result_t expected_results[$];
  tfnm_pkg::result_t oldest_result;
  int       fail_count;
  int       items_sent;
  int       sender_idle_pct;

  bit [7:0] word_buf [8];
  int       word_len;
  bit [7:0] vocab [VOCAB_MAX][8];
  int       vocab_len [VOCAB_MAX];
  int       vocab_size;

  trie_field_name_matcher #(
    .TRIE_NODES(NODE_COUNT),
    .MAX_KEYWORDS(KEYWORD_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic clear_trie_model();
    foreach (trie_edge[i]) trie_edge[i] = '0;
    foreach (node_tag[i]) node_tag[i] = '0;
    kw_node = 0;
    nodes_taken = 1;
    kw_count = 0;
    kw_failed = 1'b0;
    id_node = 0;
    id_lost = 1'b0;
    id_active = 1'b0;
  endtask

  function automatic bit trie_predict(input tfnm_pkg::request_t beat,
                                      output tfnm_pkg::result_t res);
    int  slot;
    int  child;
    int  tag;
    bit  produced;
    produced = 1'b0;
    res = '0;
    case (beat.operation)
      tfnm_pkg::OP_INSERT: begin
        if (!kw_failed) begin
          if (beat.character == tfnm_pkg::QUOTE_BYTE) begin
            kw_failed = 1'b1;
          end else begin
            slot = kw_node * 256 + int'(beat.character);
            if (trie_edge[slot] == 0) begin
              if (nodes_taken >= NODE_COUNT) begin
                kw_failed = 1'b1;
              end else begin
                trie_edge[slot] = 7'(nodes_taken);
                kw_node = nodes_taken;
                nodes_taken++;
              end
            end else begin
              kw_node = int'(trie_edge[slot]);
            end
          end
        end
      end
      tfnm_pkg::OP_CLOSE: begin
        produced = 1'b1;
        if (kw_failed || kw_count >= KEYWORD_LIMIT) begin
          res.status = tfnm_pkg::ST_REJECTED;
        end else begin
          node_tag[kw_node] = 6'(kw_count + 1);
          res.status = tfnm_pkg::ST_STORED;
          res.field_num = 5'(kw_count);
          kw_count++;
        end
        kw_node = 0;
        kw_failed = 1'b0;
      end
      tfnm_pkg::OP_MATCH: begin
        if (!id_active) begin
          id_active = 1'b1;
          id_node = 0;
          id_lost = 1'b0;
        end
        if (beat.character == tfnm_pkg::QUOTE_BYTE) begin
          tag = int'(node_tag[id_node]);
          if (id_lost || tag == 0) begin
            res.status = tfnm_pkg::ST_UNKNOWN;
          end else begin
            res.status = tfnm_pkg::ST_MATCHED;
            res.field_num = 5'(tag - 1);
          end
          produced = 1'b1;
          id_active = 1'b0;
          id_node = 0;
          id_lost = 1'b0;
        end else if (!id_lost) begin
          child = int'(trie_edge[id_node * 256 + int'(beat.character)]);
          if (child == 0) id_lost = 1'b1;
          else id_node = child;
        end
      end
      default: begin
        if (id_active) begin
          res.status = tfnm_pkg::ST_UNTERMINATED;
          produced = 1'b1;
          id_active = 1'b0;
          id_node = 0;
          id_lost = 1'b0;
        end
      end
    endcase
    return produced;
  endfunction

  task automatic note_failure(input string what, input tfnm_pkg::result_t want,
                              input tfnm_pkg::result_t got);
    if (fail_count < 10) begin
      $display("%s: expected status %0d id %0d, got status %0d id %0d",
               what, want.status, want.field_num, got.status, got.field_num);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        note_failure("result beat with none pending", '0, result);
      end else begin
        oldest_result = expected_results.pop_front();
        if (result.status !== oldest_result.status
            || result.field_num !== oldest_result.field_num) begin
          note_failure("result mismatch", oldest_result, result);
        end
      end
    end
  end

  task automatic send_beat(input tfnm_pkg::request_t beat);
    tfnm_pkg::result_t res;
    start <= 1'b1;
    request <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (trie_predict(beat, res)) expected_results.push_back(res);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      request <= tfnm_pkg::request_t'(10'($urandom_range(0, 1023)));
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic [1:0] op, input logic [7:0] ch);
    tfnm_pkg::request_t beat;
    beat.operation = op;
    beat.character = ch;
    send_beat(beat);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic bit [7:0] pick_byte();
    if ($urandom_range(3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(97, 104));
  endfunction

  task automatic insert_word();
    int prior_count;
    prior_count = kw_count;
    for (int i = 0; i < word_len; i++) send_op(tfnm_pkg::OP_INSERT, word_buf[i]);
    send_op(tfnm_pkg::OP_CLOSE, pick_byte());
    if (kw_count > prior_count && vocab_size < VOCAB_MAX) begin
      for (int i = 0; i < word_len; i++) vocab[vocab_size][i] = word_buf[i];
      vocab_len[vocab_size] = word_len;
      vocab_size++;
    end
  endtask

  task automatic match_word(input int count);
    for (int i = 0; i < count; i++) send_op(tfnm_pkg::OP_MATCH, word_buf[i]);
    send_op(tfnm_pkg::OP_MATCH, tfnm_pkg::QUOTE_BYTE);
  endtask

  task automatic load_vocab_word();
    int idx;
    idx = $urandom_range(0, vocab_size - 1);
    word_len = vocab_len[idx];
    for (int i = 0; i < word_len; i++) word_buf[i] = vocab[idx][i];
  endtask

  task automatic test_directed_cases();
    send_op(tfnm_pkg::OP_END, 8'h00);
    send_op(tfnm_pkg::OP_MATCH, tfnm_pkg::QUOTE_BYTE);
    send_op(tfnm_pkg::OP_CLOSE, 8'hFF);
    send_op(tfnm_pkg::OP_MATCH, tfnm_pkg::QUOTE_BYTE);
    send_op(tfnm_pkg::OP_INSERT, "a");
    send_op(tfnm_pkg::OP_INSERT, "b");
    send_op(tfnm_pkg::OP_CLOSE, 8'h00);
    send_op(tfnm_pkg::OP_INSERT, 8'hFF);
    send_op(tfnm_pkg::OP_INSERT, 8'h00);
    send_op(tfnm_pkg::OP_CLOSE, 8'h55);
    send_op(tfnm_pkg::OP_INSERT, "a");
    send_op(tfnm_pkg::OP_INSERT, tfnm_pkg::QUOTE_BYTE);
    send_op(tfnm_pkg::OP_CLOSE, 8'hAA);
    send_op(tfnm_pkg::OP_MATCH, "a");
    send_op(tfnm_pkg::OP_MATCH, "b");
    send_op(tfnm_pkg::OP_MATCH, tfnm_pkg::QUOTE_BYTE);
    send_op(tfnm_pkg::OP_MATCH, 8'hFF);
    send_op(tfnm_pkg::OP_MATCH, 8'h00);
    send_op(tfnm_pkg::OP_MATCH, tfnm_pkg::QUOTE_BYTE);
    send_op(tfnm_pkg::OP_MATCH, "a");
    send_op(tfnm_pkg::OP_MATCH, "x");
    send_op(tfnm_pkg::OP_MATCH, "b");
    send_op(tfnm_pkg::OP_MATCH, tfnm_pkg::QUOTE_BYTE);
    send_op(tfnm_pkg::OP_MATCH, "a");
    send_op(tfnm_pkg::OP_END, 8'hFF);
    send_op(tfnm_pkg::OP_INSERT, "a");
    send_op(tfnm_pkg::OP_INSERT, "b");
    send_op(tfnm_pkg::OP_CLOSE, 8'h7F);
  endtask

  task automatic test_vocabulary_build();
    repeat (48) begin
      if (vocab_size > 0 && $urandom_range(3) == 0) begin
        load_vocab_word();
        word_len = $urandom_range(0, word_len);
      end else begin
        word_len = $urandom_range(1, 5);
        for (int i = 0; i < word_len; i++) word_buf[i] = pick_byte();
      end
      insert_word();
    end
    // Walk fresh nodes until the trie has no room left, then overflow it once.
    while (nodes_taken < NODE_COUNT) begin
      send_op(tfnm_pkg::OP_INSERT, 8'($urandom_range(35, 255)));
    end
    send_op(tfnm_pkg::OP_INSERT, 8'($urandom_range(35, 255)));
    send_op(tfnm_pkg::OP_CLOSE, 8'h00);
    word_len = 0;
    while (kw_count < KEYWORD_LIMIT) insert_word();
    insert_word();
    insert_word();
  endtask

  task automatic test_random_identifiers(input int idle_pct, input int goal);
    int pick;
    int cut;
    sender_idle_pct = idle_pct;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 83 || (pick >= 83 && pick < 90)) load_vocab_word();
      if (pick < 55) begin
        match_word(word_len);
      end else if (pick < 65) begin
        match_word($urandom_range(0, word_len));
      end else if (pick < 75) begin
        cut = $urandom_range(0, word_len < 7 ? word_len : 7);
        word_buf[cut] = 8'($urandom_range(0, 255));
        if (cut == word_len) word_len++;
        match_word(word_len);
      end else if (pick < 83) begin
        cut = $urandom_range(0, word_len);
        for (int i = 0; i < cut; i++) send_op(tfnm_pkg::OP_MATCH, word_buf[i]);
        send_op(tfnm_pkg::OP_END, 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        cut = $urandom_range(0, word_len);
        for (int i = 0; i < cut; i++) send_op(tfnm_pkg::OP_MATCH, word_buf[i]);
        send_op(tfnm_pkg::OP_INSERT, pick_byte());
        if ($urandom_range(1) == 1) send_op(tfnm_pkg::OP_CLOSE, pick_byte());
        for (int i = cut; i < word_len; i++) send_op(tfnm_pkg::OP_MATCH, word_buf[i]);
        send_op(tfnm_pkg::OP_MATCH, tfnm_pkg::QUOTE_BYTE);
      end else begin
        send_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    fail_count = 0;
    items_sent = 0;
    vocab_size = 0;
    sender_idle_pct = 19;
    clear_trie_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    wait_for_results();
    test_vocabulary_build();
    wait_for_results();
    test_random_identifiers(19, 500);
    wait_for_results();
    test_random_identifiers(58, 780);
    wait_for_results();
    test_random_identifiers(0, 1050);
    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
